// File: hdl/gcdk_pkg.sv
// Shared constants and calendar tables for the Gregorian date keeper.
// Used by gregorian_calendar_date_keeper and its checker; depends on nothing.
`timescale 1ns / 1ps

package gcdk_pkg;

   // Parameter defaults
   localparam int MaxYearDefault  = 9999;
   localparam int AddWidthDefault = 16;

   // Fixed field widths of the item buses
   localparam int YearWidth     = 14;
   localparam int MonthWidth    = 4;
   localparam int DayWidth      = 5;
   localparam int AddFieldWidth = 16;
   localparam int OutSerialWidth = 22;
   localparam int ReqDataWidth  = 40;
   localparam int RspDataWidth  = 64;

   // Date after reset
   localparam int ResetYear   = 1970;
   localparam int ResetMonth  = 1;
   localparam int ResetDay    = 1;
   localparam int ResetSerial = 719163;
   localparam int ResetMod100 = 70;
   localparam int ResetMod400 = 370;

   // x / 100 == (x * Recip100) >> Recip100Shift for every x below 43690.
   localparam int Recip100      = 5243;
   localparam int Recip100Shift = 19;
   localparam int DaysPerYear   = 365;

   localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd12;

   // Days in all months before month m of a common year.
   function automatic logic [8:0] days_before(input logic [MonthWidth-1:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Days in month m; months outside 1..12 report 31.
   function automatic logic [DayWidth-1:0] month_days(input logic [MonthWidth-1:0] m,
                                                      input logic leap);
      logic [DayWidth-1:0] r;
      case (m) inside
         MonthFeb:                     r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:      r = 5'd30;
         default:                      r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/gregorian_calendar_date_keeper.sv
// Gregorian date keeper: stored date, serial day number and the sequencer
// that runs add-days and set-date items. Depends on gcdk_pkg.
`timescale 1ns / 1ps

// The block holds a date (reset 1970-01-01, serial day 719163, where
// 0001-01-01 is day 1) and runs one item at a time: req_tready is high only
// while the block is idle. An add-days item walks the date forward with a single
// compare-and-subtract unit, one month per cycle; 65535 days crosses at most
// about 2155 months. A rejected add-days item ends after its range check. A
// set-date item feeds one shared 14x13 multiplier that forms the year divisions
// and the serial number, then checks the date and compares it with the stored one.
// Each item returns exactly one result item, which waits on rsp_tvalid until
// taken; the next request is taken the cycle after that. Rejected items
// (zero days, a result past December 31 of MAX_YEAR, an illegal date, or a
// set date not later than the stored one) leave the date unchanged and report
// it with the accepted flag in rsp_tuser low.
module gregorian_calendar_date_keeper #(
   parameter int MAX_YEAR  = gcdk_pkg::MaxYearDefault,
   parameter int ADD_WIDTH = gcdk_pkg::AddWidthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operation (0 = add days, 1 = set date)
   input  logic                              req_tuser,
   // new_year[13:0], new_month[17:14], new_day[22:18], days_to_add[38:23], zero
   input  logic [gcdk_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted
   output logic                              rsp_tuser,
   // cur_year[13:0], cur_month[17:14], cur_day[22:18], serial_day[44:23],
   // month_length[49:45], year_length[58:50], zero
   output logic [gcdk_pkg::RspDataWidth-1:0] rsp_tdata
);
   import gcdk_pkg::*;

   localparam int YearM1      = MAX_YEAR - 1;
   localparam int LimitSerial = YearM1 * 365 + YearM1 / 4 - YearM1 / 100 + YearM1 / 400 + 365;
   localparam int SerialWidth = $clog2(LimitSerial + 1);
   localparam int AddBits     = (ADD_WIDTH < AddFieldWidth) ? ADD_WIDTH : AddFieldWidth;
   localparam int DdWidth     = ((AddBits > DayWidth) ? AddBits : DayWidth) + 1;
   localparam int ProdWidth   = 27;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_ADD_CHK = 9'b000000010,
      ST_ADD_RUN = 9'b000000100,
      ST_SET_Q1  = 9'b000001000,
      ST_SET_Q2  = 9'b000010000,
      ST_SET_Q3  = 9'b000100000,
      ST_SET_Q4  = 9'b001000000,
      ST_SET_SUM = 9'b010000000,
      ST_SET_CMP = 9'b100000000
   } state_type;

   // The response state is kept apart so that a result waits without
   // blocking the state encoding of the working sequence.
   state_type                  state_ff, state_in;
   logic                       resp_ff, resp_in;
   logic                       accepted_ff, accepted_in;

   logic [YearWidth-1:0]       ny_ff, ny_in;
   logic [MonthWidth-1:0]      nm_ff, nm_in;
   logic [DayWidth-1:0]        nd_ff, nd_in;
   logic [AddBits-1:0]         n_ff, n_in;

   logic [YearWidth-1:0]       year_ff, year_in;
   logic [MonthWidth-1:0]      month_ff, month_in;
   logic [DayWidth-1:0]        day_ff, day_in;
   logic [SerialWidth-1:0]     count_ff, count_in;
   logic [6:0]                 mod100_ff, mod100_in;
   logic [8:0]                 mod400_ff, mod400_in;

   logic [DdWidth-1:0]         dd_ff, dd_in;
   logic [ProdWidth-1:0]       prod_ff;
   logic [1:0]                 yq2_ff, yq2_in;
   logic [6:0]                 ymod100_ff, ymod100_in;
   logic [8:0]                 ymod400_ff, ymod400_in;
   logic [7:0]                 pq_ff, pq_in;
   logic [SerialWidth-1:0]     serial_ff, serial_in;
   logic                       legal_ff, legal_in;

   logic [YearWidth-1:0]       mul_a;
   logic [12:0]                mul_b;
   logic [ProdWidth-1:0]       mul_p;
   logic [YearWidth-1:0]       p_year;
   logic                       leap_cur;
   logic [DayWidth-1:0]        mlen_cur;
   logic [8:0]                 ylen_cur;
   logic [SerialWidth-1:0]     gap;
   logic [8:0]                 ymod400_new;
   logic                       leap_new;
   logic [ProdWidth-1:0]       serial_sum;
   logic [SerialWidth+OutSerialWidth-1:0] serial_wide;

   assign p_year   = ny_ff - 14'd1;
   assign leap_cur = ((year_ff[1:0] == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign mlen_cur = month_days(month_ff, leap_cur);
   assign ylen_cur = leap_cur ? 9'd366 : 9'd365;
   assign gap      = SerialWidth'(LimitSerial) - count_ff;

   // Year remainders of the new year, from its quotient and remainder by 100.
   assign ymod400_new = 9'(ymod100_ff) + 9'(yq2_ff) * 9'd100;
   assign leap_new    = ((ny_ff[1:0] == 2'd0) && (ymod100_ff != 7'd0)) || (ymod400_new == 9'd0);
   assign serial_sum  = prod_ff + ProdWidth'(p_year[YearWidth-1:2]) - ProdWidth'(pq_ff)
                        + ProdWidth'(pq_ff[7:2]) + ProdWidth'(days_before(nm_ff))
                        + ProdWidth'(nd_ff)
                        + ProdWidth'(leap_new && (nm_ff > MonthFeb));

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SET_Q1: begin
            mul_a = ny_ff;
            mul_b = 13'(Recip100);
         end
         ST_SET_Q2: begin
            mul_a = 14'(prod_ff[ProdWidth-1:Recip100Shift]);
            mul_b = 13'd100;
         end
         ST_SET_Q3: begin
            mul_a = p_year;
            mul_b = 13'(Recip100);
         end
         ST_SET_Q4: begin
            mul_a = p_year;
            mul_b = 13'(DaysPerYear);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = ProdWidth'(mul_a) * ProdWidth'(mul_b);

   always_comb begin
      state_in    = state_ff;
      resp_in     = resp_ff;
      accepted_in = accepted_ff;
      ny_in       = ny_ff;
      nm_in       = nm_ff;
      nd_in       = nd_ff;
      n_in        = n_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      count_in    = count_ff;
      mod100_in   = mod100_ff;
      mod400_in   = mod400_ff;
      dd_in       = dd_ff;
      yq2_in      = yq2_ff;
      ymod100_in  = ymod100_ff;
      ymod400_in  = ymod400_ff;
      pq_in       = pq_ff;
      serial_in   = serial_ff;
      legal_in    = legal_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (resp_ff) begin
               if (rsp_tready) begin
                  resp_in = 1'b0;
               end
            end else if (req_tvalid) begin
               ny_in       = req_tdata[13:0];
               nm_in       = req_tdata[17:14];
               nd_in       = req_tdata[22:18];
               n_in        = req_tdata[23 +: AddBits];
               accepted_in = 1'b0;
               state_in    = req_tuser ? ST_SET_Q1 : ST_ADD_CHK;
            end
         end
         ST_ADD_CHK: begin
            if ((n_ff != '0) && (count_ff <= SerialWidth'(LimitSerial))
                && (SerialWidth'(n_ff) <= gap)) begin
               dd_in       = DdWidth'(day_ff) + DdWidth'(n_ff);
               count_in    = count_ff + SerialWidth'(n_ff);
               accepted_in = 1'b1;
               state_in    = ST_ADD_RUN;
            end else begin
               resp_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ADD_RUN: begin
            // One month boundary per cycle.
            if (dd_ff > DdWidth'(mlen_cur)) begin
               dd_in = dd_ff - DdWidth'(mlen_cur);
               if (month_ff == MonthDec) begin
                  month_in  = MonthJan;
                  year_in   = year_ff + 14'd1;
                  mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
                  mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               day_in   = dd_ff[DayWidth-1:0];
               resp_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SET_Q1: begin
            state_in = ST_SET_Q2;
         end
         ST_SET_Q2: begin
            yq2_in   = prod_ff[Recip100Shift+1:Recip100Shift];
            state_in = ST_SET_Q3;
         end
         ST_SET_Q3: begin
            ymod100_in = 7'(ny_ff - prod_ff[YearWidth-1:0]);
            state_in   = ST_SET_Q4;
         end
         ST_SET_Q4: begin
            pq_in    = prod_ff[Recip100Shift+7:Recip100Shift];
            state_in = ST_SET_SUM;
         end
         ST_SET_SUM: begin
            ymod400_in = ymod400_new;
            serial_in  = SerialWidth'(serial_sum);
            legal_in   = (ny_ff != '0) && (32'(ny_ff) <= 32'(MAX_YEAR))
                         && (nm_ff >= MonthJan) && (nm_ff <= MonthDec)
                         && (nd_ff != '0) && (nd_ff <= month_days(nm_ff, leap_new));
            state_in   = ST_SET_CMP;
         end
         ST_SET_CMP: begin
            if (legal_ff && (serial_ff > count_ff)) begin
               year_in     = ny_ff;
               month_in    = nm_ff;
               day_in      = nd_ff;
               count_in    = serial_ff;
               mod100_in   = ymod100_ff;
               mod400_in   = ymod400_ff;
               accepted_in = 1'b1;
            end
            resp_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         resp_ff     <= 1'b0;
         accepted_ff <= 1'b0;
         year_ff     <= YearWidth'(ResetYear);
         month_ff    <= MonthWidth'(ResetMonth);
         day_ff      <= DayWidth'(ResetDay);
         count_ff    <= SerialWidth'(ResetSerial);
         mod100_ff   <= 7'(ResetMod100);
         mod400_ff   <= 9'(ResetMod400);
      end else begin
         state_ff    <= state_in;
         resp_ff     <= resp_in;
         accepted_ff <= accepted_in;
         year_ff     <= year_in;
         month_ff    <= month_in;
         day_ff      <= day_in;
         count_ff    <= count_in;
         mod100_ff   <= mod100_in;
         mod400_ff   <= mod400_in;
      end
   end

   always_ff @(posedge clock) begin
      ny_ff      <= ny_in;
      nm_ff      <= nm_in;
      nd_ff      <= nd_in;
      n_ff       <= n_in;
      dd_ff      <= dd_in;
      prod_ff    <= mul_p;
      yq2_ff     <= yq2_in;
      ymod100_ff <= ymod100_in;
      ymod400_ff <= ymod400_in;
      pq_ff      <= pq_in;
      serial_ff  <= serial_in;
      legal_ff   <= legal_in;
   end

   assign serial_wide = {{OutSerialWidth{1'b0}}, count_ff};

   assign req_tready = (state_ff == ST_IDLE) && !resp_ff;
   assign rsp_tvalid = resp_ff;
   assign rsp_tuser  = accepted_ff;
   assign rsp_tdata  = {5'd0, ylen_cur, mlen_cur, serial_wide[OutSerialWidth-1:0],
                        day_ff, month_ff, year_ff};

endmodule

// File: hdl/gcdk_checker.sv
// Port-level checker for gregorian_calendar_date_keeper, bound into that module.
// Depends on gcdk_pkg.
`timescale 1ns / 1ps

module gcdk_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic                              rsp_tuser,
   input logic [gcdk_pkg::RspDataWidth-1:0] rsp_tdata
);
   import gcdk_pkg::*;

   logic [OutSerialWidth-1:0] prev_serial_ff, prev_serial_in;
   logic [OutSerialWidth-1:0] rsp_serial;
   logic                      rsp_fire;

   assign rsp_serial = rsp_tdata[44:23];
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign prev_serial_in = rsp_fire ? rsp_serial : prev_serial_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_serial_ff <= OutSerialWidth'(ResetSerial);
      end else begin
         prev_serial_ff <= prev_serial_in;
      end
   end

   // Only one item is in flight: no request is taken while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request ready while a result is pending");

   // Once an item is taken, the block stops taking items on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken back to back");

   // An accepted operation moves the date forward; a rejected one keeps it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tuser) |-> (rsp_serial > prev_serial_ff))
      else $error("accepted result did not advance the serial day");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_tuser) |-> (rsp_serial == prev_serial_ff))
      else $error("rejected result changed the serial day");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

endmodule

bind gregorian_calendar_date_keeper gcdk_checker u_gcdk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
